FILE: design/sri_pkg.sv
// shared constants and helpers for the segment/rectangle hit test
`timescale 1ns / 1ps
package sri_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int QUEUE_DEPTH = 4;

  // bits of one queued item for a given coordinate width
  function automatic int entry_bits(input int w);
    return 3 + 2 * w + 6 * (w + 2);
  endfunction

endpackage

FILE: design/sri_front.sv
// front stage: edge math, trivial reject, containment, x clipping
`timescale 1ns / 1ps
module sri_front #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic signed [COORD_BITS-1:0]                     start_x,
  input  logic signed [COORD_BITS-1:0]                     start_y,
  input  logic signed [COORD_BITS-1:0]                     end_x,
  input  logic signed [COORD_BITS-1:0]                     end_y,
  input  logic signed [COORD_BITS-1:0]                     box_left,
  input  logic signed [COORD_BITS-1:0]                     box_top,
  input  logic        [COORD_BITS-2:0]                     box_width,
  input  logic        [COORD_BITS-2:0]                     box_height,
  output logic                                             push,
  output logic [sri_pkg::entry_bits(COORD_BITS)-1:0]       push_data,
  input  logic                                             full
);
  import sri_pkg::*;

  localparam int W = COORD_BITS;
  localparam int E = W + 2;

  typedef struct packed {
    logic                decided;
    logic                early_hit;
    logic                vert;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] y2;
    logic signed [E-1:0] top;
    logic signed [E-1:0] bot;
    logic signed [E-1:0] dy;
    logic signed [E-1:0] dx;
    logic signed [E-1:0] alo;
    logic signed [E-1:0] ahi;
  } entry_t;

  logic signed [E-1:0] x1, y1, x2, y2, l, t, r, b;
  logic signed [E-1:0] lox, hix, lox_c, hix_c;
  logic                reject, in1, in2, empty;
  entry_t              ent;
  entry_t              held;
  logic                held_valid;

  always_comb begin
    x1 = E'(start_x);
    y1 = E'(start_y);
    x2 = E'(end_x);
    y2 = E'(end_y);
    l  = E'(box_left);
    t  = E'(box_top);
    r  = l + signed'({3'b000, box_width});
    b  = t + signed'({3'b000, box_height});
    reject = (x1 < l && x2 < l) || (y1 < t && y2 < t) ||
             (x1 > r && x2 > r) || (y1 > b && y2 > b);
    in1 = (l <= x1) && (x1 < r) && (t <= y1) && (y1 < b);
    in2 = (l <= x2) && (x2 < r) && (t <= y2) && (y2 < b);
    lox = (x1 < x2) ? x1 : x2;
    hix = (x1 < x2) ? x2 : x1;
    hix_c = (hix > r) ? r : hix;
    lox_c = (lox < l) ? l : lox;
    empty = lox_c > hix_c;
    ent.decided   = reject || in1 || in2 || empty;
    ent.early_hit = !reject && (in1 || in2);
    ent.vert      = (x2 == x1);
    ent.y1        = start_y;
    ent.y2        = end_y;
    ent.top       = t;
    ent.bot       = b;
    ent.dy        = y2 - y1;
    ent.dx        = x2 - x1;
    ent.alo       = lox_c - x1;
    ent.ahi       = hix_c - x1;
  end

  assign push      = held_valid && !full;
  assign in_ready  = !held_valid || !full;
  assign push_data = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held <= ent;
    end
  end

endmodule

FILE: design/sri_queue.sv
// short queue between the classify front and the divide back end
`timescale 1ns / 1ps
module sri_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sri_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import sri_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on transfer in");

endmodule

FILE: design/sri_back.sv
// back end: products, pipelined restoring division, y-span test, output register
`timescale 1ns / 1ps
module sri_back #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       empty,
  output logic                                       pop,
  input  logic [sri_pkg::entry_bits(COORD_BITS)-1:0] pop_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       hit
);
  import sri_pkg::*;

  localparam int W = COORD_BITS;
  localparam int E = W + 2;

  typedef struct packed {
    logic                decided;
    logic                early_hit;
    logic                vert;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] y2;
    logic signed [E-1:0] top;
    logic signed [E-1:0] bot;
    logic signed [E-1:0] dy;
    logic signed [E-1:0] dx;
    logic signed [E-1:0] alo;
    logic signed [E-1:0] ahi;
  } entry_t;

  typedef struct packed {
    logic                valid;
    logic                decided;
    logic                early_hit;
    logic                vert;
    logic                neg_lo;
    logic                neg_hi;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] y2;
    logic signed [E-1:0] top;
    logic signed [E-1:0] bot;
    logic        [W-1:0] d;
  } ctl_t;

  entry_t        ent;
  logic          adv;
  ctl_t          ctl [W+1];
  logic [W-1:0]  rl  [W+1];
  logic [W-1:0]  rh  [W+1];
  logic [W-1:0]  ll  [W+1];
  logic [W-1:0]  lh  [W+1];
  logic [W-1:0]  ql  [W+1];
  logic [W-1:0]  qh  [W+1];
  logic [W-1:0]  mdy, mlo, mhi, mdx;
  logic [2*W-1:0] plo, phi;

  function automatic logic [W-1:0] mag(input logic signed [E-1:0] v);
    logic signed [E-1:0] a;
    a = v[E-1] ? -v : v;
    return a[W-1:0];
  endfunction

  assign ent = entry_t'(pop_data);
  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  always_comb begin
    mdy = mag(ent.dy);
    mlo = mag(ent.alo);
    mhi = mag(ent.ahi);
    mdx = mag(ent.dx);
    plo = mdy * mlo;
    phi = mdy * mhi;
  end

  // stage 0: products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (adv) begin
      ctl[0].valid <= !empty;
    end
    if (adv) begin
      ctl[0].decided   <= ent.decided;
      ctl[0].early_hit <= ent.early_hit;
      ctl[0].vert      <= ent.vert;
      ctl[0].neg_lo    <= ent.dy[E-1] ^ ent.alo[E-1] ^ ent.dx[E-1];
      ctl[0].neg_hi    <= ent.dy[E-1] ^ ent.ahi[E-1] ^ ent.dx[E-1];
      ctl[0].y1        <= ent.y1;
      ctl[0].y2        <= ent.y2;
      ctl[0].top       <= ent.top;
      ctl[0].bot       <= ent.bot;
      ctl[0].d         <= mdx;
      rl[0] <= plo[2*W-1:W];
      rh[0] <= phi[2*W-1:W];
      ll[0] <= plo[W-1:0];
      lh[0] <= phi[W-1:0];
      ql[0] <= '0;
      qh[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] tl, th;
    logic       gl, gh;
    logic [W:0] sl, sh;
    always_comb begin
      tl = {rl[k], ll[k][W-1-k]};
      th = {rh[k], lh[k][W-1-k]};
      gl = tl >= {1'b0, ctl[k].d};
      gh = th >= {1'b0, ctl[k].d};
      sl = tl - {1'b0, ctl[k].d};
      sh = th - {1'b0, ctl[k].d};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].valid <= 1'b0;
      end else if (adv) begin
        ctl[k+1].valid <= ctl[k].valid;
      end
      if (adv) begin
        ctl[k+1].decided   <= ctl[k].decided;
        ctl[k+1].early_hit <= ctl[k].early_hit;
        ctl[k+1].vert      <= ctl[k].vert;
        ctl[k+1].neg_lo    <= ctl[k].neg_lo;
        ctl[k+1].neg_hi    <= ctl[k].neg_hi;
        ctl[k+1].y1        <= ctl[k].y1;
        ctl[k+1].y2        <= ctl[k].y2;
        ctl[k+1].top       <= ctl[k].top;
        ctl[k+1].bot       <= ctl[k].bot;
        ctl[k+1].d         <= ctl[k].d;
        rl[k+1] <= gl ? sl[W-1:0] : tl[W-1:0];
        rh[k+1] <= gh ? sh[W-1:0] : th[W-1:0];
        ll[k+1] <= ll[k];
        lh[k+1] <= lh[k];
        ql[k+1] <= ql[k] | (W'(gl) << (W - 1 - k));
        qh[k+1] <= qh[k] | (W'(gh) << (W - 1 - k));
      end
    end
  end

  // final y-span test
  logic signed [E-1:0] ya, yb, yl, yh, qa, qb, ylc, yhc;
  logic                hit_next;
  ctl_t                cf;

  always_comb begin
    cf = ctl[W];
    qa = signed'({2'b00, ql[W]});
    qb = signed'({2'b00, qh[W]});
    if (cf.vert) begin
      ya = E'(cf.y1);
      yb = E'(cf.y2);
    end else begin
      ya = E'(cf.y1) + (cf.neg_lo ? -qa : qa);
      yb = E'(cf.y1) + (cf.neg_hi ? -qb : qb);
    end
    yl  = (ya > yb) ? yb : ya;
    yh  = (ya > yb) ? ya : yb;
    yhc = (yh > cf.bot) ? cf.bot : yh;
    ylc = (yl < cf.top) ? cf.top : yl;
    hit_next = cf.decided ? cf.early_hit : !(ylc > yhc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cf.valid;
    end
    if (adv) begin
      hit <= hit_next;
    end
  end

  a_pop_on_adv: assert property (@(posedge clk) disable iff (rst) pop |-> adv)
    else $error("queue popped while pipeline stalled");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctl[0].valid) && $stable(ctl[W].valid))
    else $error("pipeline moved during stall");
  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    adv |=> (ctl[1].valid == $past(ctl[0].valid)))
    else $error("stage valid lost on advance");

endmodule

FILE: design/segment_rect_intersect_test.sv
// Segment versus axis-aligned rectangle hit test, top level.
// Input channel: in_valid/in_ready with the two endpoints, the rectangle's
// left/top edges (signed Q15.8) and its width/height (unsigned Q15.8).
// Output channel: out_valid/out_ready carrying one hit bit per item, in order.
// One item is accepted every cycle and one result leaves every cycle while
// the receiver takes them.
// With no stall, an item passes from the input transfer through the front
// register, one queue slot, the multiply stage, COORD_BITS restoring
// division stages (one quotient bit each), and the output register to
// out_valid. The division pipeline sets the depth.
// Reset (rst, synchronous) empties the queue and clears all valid bits.
// When out_ready is low while out_valid is high the back end holds; the
// queue of QUEUE_DEPTH items and the front register keep taking items until
// they fill, then in_ready drops.
`timescale 1ns / 1ps
module segment_rect_intersect_test #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic        [COORD_BITS-2:0] box_width,
  input  logic        [COORD_BITS-2:0] box_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit
);
  import sri_pkg::*;

  localparam int EB = entry_bits(COORD_BITS);

  logic          push, full, pop, empty;
  logic [EB-1:0] push_data, pop_data;

  sri_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .start_x, .start_y, .end_x, .end_y,
    .box_left, .box_top, .box_width, .box_height,
    .push, .push_data, .full
  );

  sri_queue #(.WIDTH(EB), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .pop_data, .empty
  );

  sri_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .empty, .pop, .pop_data, .out_valid, .out_ready, .hit
  );

endmodule

FILE: bench/segment_rect_intersect_test_tb.sv
// testbench for the segment/rectangle hit test: directed table plus random pairs, checked in order
`timescale 1ns / 1ps
module segment_rect_intersect_test_tb;

  localparam int W = sri_pkg::COORD_BITS_DEF;
  localparam int LATENCY = W + 4;
  localparam int N_RANDOM = 1130;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0] EMAX = {(W-1){1'b1}};
  localparam int HIT_UNKNOWN = 2;

  typedef struct packed {
    logic signed [W-1:0] sx, sy, ex, ey, left, top;
    logic [W-2:0] wid, hgt;
  } query_t;

  typedef struct {
    query_t q;
    int want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic signed [W-1:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic signed [W-1:0] box_left = 0, box_top = 0;
  logic [W-2:0] box_width = 0, box_height = 0;
  logic in_ready, out_valid, hit;

  segment_rect_intersect_test #(.COORD_BITS(W)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .box_left(box_left), .box_top(box_top), .box_width(box_width),
    .box_height(box_height), .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  always #5 clk = ~clk;

  bit expected_hits[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_hits = 0;
  bit calm = 0;
  bit sending_done = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  // trunc(a * b / d), exact
  function automatic longint scaled_div(longint a, longint b, longint d);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return longint'(p / 128'(d));
  endfunction

  function automatic bit predict_hit(query_t q);
    longint x1, y1, x2, y2, l, t, r, b, lox, hix, loy, hiy, dx, tmp;
    x1 = q.sx; y1 = q.sy; x2 = q.ex; y2 = q.ey;
    l = q.left; t = q.top;
    r = l + longint'({1'b0, q.wid});
    b = t + longint'({1'b0, q.hgt});
    if ((x1 < l && x2 < l) || (y1 < t && y2 < t) || (x1 > r && x2 > r) || (y1 > b && y2 > b))
      return 0;
    if ((l <= x1 && x1 < r && t <= y1 && y1 < b) || (l <= x2 && x2 < r && t <= y2 && y2 < b))
      return 1;
    lox = x1 < x2 ? x1 : x2;
    hix = x1 < x2 ? x2 : x1;
    if (hix > r) hix = r;
    if (lox < l) lox = l;
    if (lox > hix) return 0;
    loy = y1;
    hiy = y2;
    dx = x2 - x1;
    if (dx != 0) begin
      loy = y1 + scaled_div(y2 - y1, lox - x1, dx);
      hiy = y1 + scaled_div(y2 - y1, hix - x1, dx);
    end
    if (loy > hiy) begin
      tmp = loy; loy = hiy; hiy = tmp;
    end
    if (hiy > b) hiy = b;
    if (loy < t) loy = t;
    return loy <= hiy;
  endfunction

  function automatic logic signed [W-1:0] rand_coord(int mode);
    logic signed [W-1:0] v;
    case (mode)
      0: v = W'($urandom);
      1: v = $urandom_range(0, 1) ? CMAX - W'($urandom_range(0, 3))
                                  : CMIN + W'($urandom_range(0, 3));
      default: v = W'($urandom_range(0, 8191)) - W'(4096);
    endcase
    return v;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9) < 7 ? 2 : ($urandom_range(0, 1) ? 0 : 1);
    q.sx = rand_coord(mode); q.sy = rand_coord(mode);
    q.ex = rand_coord(mode); q.ey = rand_coord(mode);
    q.left = rand_coord(mode); q.top = rand_coord(mode);
    if (mode == 2) begin
      q.wid = (W-1)'($urandom_range(0, 3000));
      q.hgt = (W-1)'($urandom_range(0, 3000));
      if ($urandom_range(0, 7) == 0) q.ex = q.sx;
      if ($urandom_range(0, 7) == 0) q.ey = q.sy;
      if ($urandom_range(0, 9) == 0) q.wid = '0;
      if ($urandom_range(0, 9) == 0) q.hgt = '0;
    end else begin
      q.wid = (W-1)'($urandom);
      q.hgt = (W-1)'($urandom);
      if (mode == 1) begin
        q.wid = EMAX - (W-1)'($urandom_range(0, 3));
        q.hgt = EMAX - (W-1)'($urandom_range(0, 3));
      end
    end
    return q;
  endfunction

  function automatic row_t mk(int sx, int sy, int ex, int ey, int l, int t, int w, int h,
                              int want);
    row_t r;
    r.q.sx = W'(sx); r.q.sy = W'(sy); r.q.ex = W'(ex); r.q.ey = W'(ey);
    r.q.left = W'(l); r.q.top = W'(t); r.q.wid = (W-1)'(w); r.q.hgt = (W-1)'(h);
    r.want = want;
    return r;
  endfunction

  task automatic send(query_t q, int want);
    bit p;
    p = predict_hit(q);
    if (want != HIT_UNKNOWN && want != p)
      $display("%0t table row disagrees with prediction: typed %0d predicted %0d", $time, want, p);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {start_x, start_y, end_x, end_y, box_left, box_top, box_width, box_height} <= q;
    expected_hits.push_back(want == HIT_UNKNOWN ? p : bit'(want));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_got++;
        if (expected_hits.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual hit=%0b", $time, hit);
          errors++;
        end else begin
          if (hit !== expected_hits[0]) begin
            $display("%0t hit mismatch: expected %0b actual %0b", $time, expected_hits[0], hit);
            errors++;
          end
          if (expected_hits[0]) n_hits++;
          void'(expected_hits.pop_front());
        end
      end
      out_ready <= calm || sending_done || ($urandom_range(0, 99) >= 18);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  row_t table_rows[$];
  query_t q;
  int k;

  initial begin
    // trivial rejects on each side, endpoint inside, crossings, extremes
    table_rows.push_back(mk(-100, 0, -50, 10, 0, 0, 256, 256, 0));
    table_rows.push_back(mk(10, -90, 20, -5, 0, 0, 256, 256, 0));
    table_rows.push_back(mk(300, 10, 400, 20, 0, 0, 256, 256, 0));
    table_rows.push_back(mk(10, 300, 20, 400, 0, 0, 256, 256, 0));
    table_rows.push_back(mk(10, 10, 1000, 1000, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(-500, -500, 100, 100, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(-100, 128, 500, 128, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(128, -100, 128, 500, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(-100, 300, 300, -100, 0, 0, 256, 256, 1));
    table_rows.push_back(mk(-100, 250, 100, 450, 0, 0, 256, 256, 0));
    table_rows.push_back(mk(-100, 128, 500, 128, 0, 0, 0, 0, HIT_UNKNOWN));
    table_rows.push_back(mk(0, -100, 0, 500, 0, 0, 0, 0, HIT_UNKNOWN));
    table_rows.push_back(mk(256, 256, 256, 256, 0, 0, 256, 256, HIT_UNKNOWN));
    table_rows.push_back(mk(-7, 3, 517, 259, 0, 0, 256, 256, HIT_UNKNOWN));
    table_rows.push_back(mk(CMIN, CMIN, CMAX, CMAX, 0, 0, 1, 1, HIT_UNKNOWN));
    table_rows.push_back(mk(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, EMAX, EMAX, HIT_UNKNOWN));
    table_rows.push_back(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, EMAX, EMAX, 1));
    table_rows.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, 0, 0, 0));
    table_rows.push_back(mk(CMIN, 0, CMAX, 1, CMIN, CMIN, EMAX, EMAX, HIT_UNKNOWN));
    table_rows.push_back(mk(-1, -1, -1, -1, -1, -1, EMAX, EMAX, 1));

    repeat (4) @(posedge clk);
    rst <= 0;
    foreach (table_rows[i]) send(table_rows[i].q, table_rows[i].want);
    for (k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 400 && k < 550);
      q = rand_query();
      send(q, HIT_UNKNOWN);
    end
    calm = 0;
    in_valid <= 0;
    sending_done = 1;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("sent %0d segment/box pairs (%0d table rows), %0d results checked, %0d hits",
             n_sent, table_rows.size(), n_got, n_hits);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
